FILE: design/alle_pkg.sv
// ----------------------------------------------------------------------------
// Linked-list engine package
// Command and status codes shared by the linked-list engine.
// ----------------------------------------------------------------------------
package alle_pkg;

	// Command codes carried on the cmd field.
	localparam logic [2:0] CMD_CREATE = 3'd0;
	localparam logic [2:0] CMD_APPEND = 3'd1;
	localparam logic [2:0] CMD_INSERT = 3'd2;
	localparam logic [2:0] CMD_DELETE = 3'd3;
	localparam logic [2:0] CMD_READ   = 3'd4;

	// Status codes returned with every result.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_NOMATCH = 2'd2;
	localparam logic [1:0] ST_PAST    = 2'd3;

endpackage

FILE: design/array_linked_list_engine.sv
// ----------------------------------------------------------------------------
// Array linked-list engine
// Several singly linked lists in one shared node store, with a bump allocator
// and a small sequencer that walks the lists one node per memory read.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+-----------------------------------------
//  in      | input     | in_valid / in_stall   | cmd, list_handle, position, rec_id, rec_year
//  out     | output    | out_valid / out_stall | status, new_handle, out_id, out_year
//
//  Create and error cases go from decode straight to the result; append, insert
//  and read walk the list with one node read and one evaluation per node, and
//  append and insert then write the new node and link it in; delete reads each
//  successor in turn and compares its key. The walk is bound by the single read
//  port of the node store.
//  Reset clears the free pointer and control state only; the node store holds
//  no reset value and needs no clearing pass.
//  The input is stalled while a command is in progress. A finished result waits
//  in the output register, and the next command is taken while it waits.
//
module array_linked_list_engine
	import alle_pkg::*;
#(
	parameter int STORE_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic        [2:0]  cmd,
	input  logic        [7:0]  list_handle,
	input  logic        [7:0]  position,
	input  logic signed [31:0] rec_id,
	input  logic        [15:0] rec_year,
	output logic               out_valid,
	input  logic               out_stall,
	output logic        [1:0]  status,
	output logic        [7:0]  new_handle,
	output logic signed [31:0] out_id,
	output logic        [15:0] out_year
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int FW = AW + 1;
	localparam int CW = (FW > 8) ? FW : 8;
	localparam logic [FW-1:0] NO_LINK = FW'(STORE_DEPTH);
	localparam logic [CW-1:0] WALK_MAX = CW'(STORE_DEPTH);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_DISP = 8'b0000_0010,
		S_RD   = 8'b0000_0100,
		S_EVAL = 8'b0000_1000,
		S_RD2  = 8'b0001_0000,
		S_CMP  = 8'b0010_0000,
		S_LINK = 8'b0100_0000,
		S_RESP = 8'b1000_0000
	} state_t;

	// Node store.
	logic [FW-1:0] link_mem [STORE_DEPTH];
	logic [31:0]   id_mem   [STORE_DEPTH];
	logic [15:0]   year_mem [STORE_DEPTH];

	state_t        state_q, state_d;
	logic [FW-1:0] fp_q, fp_d;
	logic          out_valid_q;

	logic [2:0]    cmd_q;
	logic [7:0]    handle_q;
	logic [7:0]    pos_q;
	logic [31:0]   id_q;
	logic [15:0]   year_q;
	logic [AW-1:0] cur_q, cur_d;
	logic [AW-1:0] addr_q, addr_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [FW-1:0] link_rd_q;
	logic [31:0]   id_rd_q;
	logic [15:0]   year_rd_q;

	logic [1:0]    res_status_q, res_status_d;
	logic [7:0]    res_handle_q, res_handle_d;
	logic [31:0]   res_id_q, res_id_d;
	logic [15:0]   res_year_q, res_year_d;

	logic [1:0]    out_status_q;
	logic [7:0]    out_handle_q;
	logic [31:0]   out_id_q;
	logic [15:0]   out_year_q;

	logic          in_xfer;
	logic          out_load;
	logic          rd_en;
	logic          wr_node;
	logic          wr_link;
	logic [AW-1:0] wr_addr;
	logic [FW-1:0] wr_link_data;
	logic [31:0]   wr_id;
	logic [15:0]   wr_year;
	logic          full;
	logic          handle_ok;
	logic          at_end;
	logic          at_pos;
	logic          key_match;

	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_load  = (state_q == S_RESP) && (!out_valid_q || !out_stall);

	assign full      = (fp_q == NO_LINK);
	assign handle_ok = (CW'(handle_q) < CW'(fp_q));
	assign at_end    = (link_rd_q >= NO_LINK);
	assign at_pos    = (cnt_q == CW'(pos_q));
	assign key_match = (id_rd_q == id_q) && (year_rd_q == year_q);

	// Sequencer: decode, walk, update and result hand-off.
	always_comb begin
		state_d      = state_q;
		fp_d         = fp_q;
		cur_d        = cur_q;
		addr_d       = addr_q;
		cnt_d        = cnt_q;
		res_status_d = res_status_q;
		res_handle_d = res_handle_q;
		res_id_d     = res_id_q;
		res_year_d   = res_year_q;
		rd_en        = 1'b0;
		wr_node      = 1'b0;
		wr_link      = 1'b0;
		wr_addr      = cur_q;
		wr_link_data = NO_LINK;
		wr_id        = id_q;
		wr_year      = year_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				res_status_d = ST_OK;
				res_handle_d = 8'd0;
				res_id_d     = 32'd0;
				res_year_d   = 16'd0;
				cur_d        = AW'(handle_q);
				addr_d       = AW'(handle_q);
				cnt_d        = '0;
				state_d      = S_RESP;
				unique case (cmd_q)
					CMD_CREATE: begin
						if (full) begin
							res_status_d = ST_FULL;
						end else begin
							wr_node      = 1'b1;
							wr_addr      = AW'(fp_q);
							wr_id        = 32'd0;
							wr_year      = 16'd0;
							res_handle_d = 8'(fp_q);
							fp_d         = fp_q + FW'(1);
						end
					end
					CMD_APPEND, CMD_INSERT: begin
						if (!handle_ok) begin
							res_status_d = ST_PAST;
						end else if (full) begin
							res_status_d = ST_FULL;
						end else begin
							state_d = S_RD;
						end
					end
					CMD_DELETE: begin
						if (!handle_ok) begin
							res_status_d = ST_PAST;
						end else begin
							state_d = S_RD;
						end
					end
					CMD_READ: begin
						if (!handle_ok || pos_q == 8'd0) begin
							res_status_d = ST_PAST;
						end else begin
							state_d = S_RD;
						end
					end
					default: begin
						state_d = S_RESP;
					end
				endcase
			end
			S_RD: begin
				rd_en   = 1'b1;
				state_d = S_EVAL;
			end
			S_EVAL: begin
				state_d = S_RESP;
				unique case (cmd_q)
					CMD_APPEND: begin
						if (cnt_q == WALK_MAX || at_end) begin
							wr_node = 1'b1;
							wr_addr = AW'(fp_q);
							state_d = S_LINK;
						end else begin
							cur_d   = link_rd_q[AW-1:0];
							addr_d  = link_rd_q[AW-1:0];
							cnt_d   = cnt_q + CW'(1);
							state_d = S_RD;
						end
					end
					CMD_INSERT: begin
						if (at_pos) begin
							wr_node      = 1'b1;
							wr_addr      = AW'(fp_q);
							wr_link_data = link_rd_q;
							state_d      = S_LINK;
						end else if (at_end) begin
							res_status_d = ST_PAST;
						end else begin
							cur_d   = link_rd_q[AW-1:0];
							addr_d  = link_rd_q[AW-1:0];
							cnt_d   = cnt_q + CW'(1);
							state_d = S_RD;
						end
					end
					CMD_READ: begin
						if (at_pos) begin
							res_id_d   = id_rd_q;
							res_year_d = year_rd_q;
						end else if (at_end) begin
							res_status_d = ST_PAST;
						end else begin
							cur_d   = link_rd_q[AW-1:0];
							addr_d  = link_rd_q[AW-1:0];
							cnt_d   = cnt_q + CW'(1);
							state_d = S_RD;
						end
					end
					CMD_DELETE: begin
						if (cnt_q == WALK_MAX || at_end) begin
							res_status_d = ST_NOMATCH;
						end else begin
							addr_d  = link_rd_q[AW-1:0];
							state_d = S_RD2;
						end
					end
					default: begin
						state_d = S_RESP;
					end
				endcase
			end
			S_RD2: begin
				rd_en   = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				// The read data now holds the successor's link, which is the
				// next link to test when the keys differ.
				if (key_match) begin
					wr_link      = 1'b1;
					wr_link_data = link_rd_q;
					state_d      = S_RESP;
				end else begin
					cur_d   = addr_q;
					cnt_d   = cnt_q + CW'(1);
					state_d = S_EVAL;
				end
			end
			S_LINK: begin
				wr_link      = 1'b1;
				wr_link_data = fp_q;
				fp_d         = fp_q + FW'(1);
				state_d      = S_RESP;
			end
			S_RESP: begin
				if (!out_valid_q || !out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fp_q    <= fp_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Command, walk and result payload registers.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q    <= cmd;
			handle_q <= list_handle;
			pos_q    <= position;
			id_q     <= rec_id;
			year_q   <= rec_year;
		end
		cur_q        <= cur_d;
		addr_q       <= addr_d;
		cnt_q        <= cnt_d;
		res_status_q <= res_status_d;
		res_handle_q <= res_handle_d;
		res_id_q     <= res_id_d;
		res_year_q   <= res_year_d;
		if (out_load) begin
			out_status_q <= res_status_q;
			out_handle_q <= res_handle_q;
			out_id_q     <= res_id_q;
			out_year_q   <= res_year_q;
		end
	end

	// Node store write port.
	always_ff @(posedge clk) begin
		if (wr_node || wr_link) begin
			link_mem[wr_addr] <= wr_link_data;
		end
		if (wr_node) begin
			id_mem[wr_addr]   <= wr_id;
			year_mem[wr_addr] <= wr_year;
		end
	end

	// Node store read port, registered.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			link_rd_q <= link_mem[addr_q];
			id_rd_q   <= id_mem[addr_q];
			year_rd_q <= year_mem[addr_q];
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign new_handle = out_handle_q;
	assign out_id     = out_id_q;
	assign out_year   = out_year_q;

`ifndef ASSERT_OFF
	// The free pointer never passes the end of the store.
	a_fp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fp_q <= NO_LINK)
		else $error("free pointer beyond store depth");

	// The free pointer holds or advances by one node per cycle.
	a_fp_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (fp_q == $past(fp_q)) || (fp_q == $past(fp_q) + FW'(1)))
		else $error("free pointer moved by more than one node");

	// A transfer in starts a command, so the input stalls in the next cycle.
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after a transfer");

	// The store is written only while a command is in progress.
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) || (state_q == S_RESP) |-> !wr_node && !wr_link)
		else $error("node store written outside a command");
`endif

endmodule
